[design/assert_macros.svh]
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define FWSK_ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// next-cycle implication, disabled during reset
`define FWSK_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

[design/fwsk_pkg.sv]
// types, constants and helpers for the four wheel steering kinematics block
`timescale 1ns / 1ps

package fwsk_pkg;

    // register indexes
    localparam logic [7:0] REG_MIN_RADIUS     = 8'd0;
    localparam logic [7:0] REG_HALF_WHEELBASE = 8'd1;
    localparam logic [7:0] REG_HALF_TRACK     = 8'd2;
    localparam logic [7:0] REG_STEER_DEADBAND = 8'd3;

    // register reset values
    localparam logic [14:0] MIN_RADIUS_RST     = 15'd4096;
    localparam logic [14:0] HALF_WHEELBASE_RST = 15'd2048;
    localparam logic [14:0] HALF_TRACK_RST     = 15'd1434;
    localparam logic [11:0] STEER_DEADBAND_RST = 12'd20;

    localparam int CORDIC_STAGES_DEF = 16;

    // datapath widths
    localparam int VEC_W   = 48;   // cordic x and y
    localparam int ANG_W   = 33;   // cordic angle accumulator
    localparam int LEN_W   = 47;   // wheel length magnitude
    localparam int RQ_W    = 27;   // radius quotient
    localparam int RDEN_W  = 17;   // steer magnitude
    localparam int PREM_W  = 63;   // power dividend
    localparam int PQ_W    = 16;   // power quotient

    localparam logic [13:0] ANGLE_MAX = 14'd9000;

    // atan(2^-i) with 2^30 units per quarter turn
    localparam logic [30:0] ATAN_TAB [32] = '{
        31'd536870912, 31'd316933406, 31'd167458907, 31'd85004756, 31'd42667331,
        31'd21354465, 31'd10679838, 31'd5340245, 31'd2670163, 31'd1335087,
        31'd667544, 31'd333772, 31'd166886, 31'd83443, 31'd41722, 31'd20861,
        31'd10430, 31'd5215, 31'd2608, 31'd1304, 31'd652, 31'd326, 31'd163,
        31'd81, 31'd41, 31'd20, 31'd10, 31'd5, 31'd3, 31'd1, 31'd1, 31'd0
    };

    // one wheel's rotating vector
    typedef struct packed {
        logic signed [VEC_W-1:0] px;
        logic signed [VEC_W-1:0] py;
        logic signed [ANG_W-1:0] z;
    } vec_t;

    // arithmetic shift that truncates toward zero
    function automatic logic signed [VEC_W-1:0] shr_tz(input logic signed [VEC_W-1:0] v,
                                                      input int unsigned s);
        logic [VEC_W-1:0] m;
        m = v[VEC_W-1] ? VEC_W'(-v) : VEC_W'(v);
        m = m >> s;
        return v[VEC_W-1] ? $signed(-m) : $signed(m);
    endfunction

endpackage

[design/fwsk_div_cell.sv]
// one restoring division step over several lanes sharing a divisor
`timescale 1ns / 1ps

module fwsk_div_cell #(
    parameter int LANES  = 1,
    parameter int REM_W  = 27,
    parameter int DEN_W  = 17,
    parameter int Q_W    = 27,
    parameter int SHIFT  = 0,
    parameter int SIDE_W = 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [LANES-1:0][REM_W-1:0]   in_rem,
    input  logic [DEN_W-1:0]              in_den,
    input  logic [LANES-1:0][Q_W-1:0]     in_quo,
    input  logic [SIDE_W-1:0]             in_side,
    output logic                          out_valid,
    output logic [LANES-1:0][REM_W-1:0]   out_rem,
    output logic [DEN_W-1:0]              out_den,
    output logic [LANES-1:0][Q_W-1:0]     out_quo,
    output logic [SIDE_W-1:0]             out_side
);

    localparam int CMP_W = (REM_W > DEN_W + SHIFT) ? REM_W : DEN_W + SHIFT;

    logic                        valid_reg, valid_next;
    logic [LANES-1:0][REM_W-1:0] rem_reg, rem_next;
    logic [LANES-1:0][Q_W-1:0]   quo_reg, quo_next;
    logic [DEN_W-1:0]            den_reg;
    logic [SIDE_W-1:0]           side_reg;
    logic [CMP_W-1:0]            trial;
    logic [CMP_W-1:0]            rem_ext;
    logic [CMP_W-1:0]            diff;

    // trial subtract of the shifted divisor in each lane
    always_comb begin
        trial = CMP_W'(in_den) << SHIFT;
        rem_ext = '0;
        diff = '0;
        for (int l = 0; l < LANES; l++) begin
            rem_ext = CMP_W'(in_rem[l]);
            diff = rem_ext - trial;
            if (rem_ext >= trial) begin
                rem_next[l] = diff[REM_W-1:0];
                quo_next[l] = {in_quo[l][Q_W-2:0], 1'b1};
            end else begin
                rem_next[l] = in_rem[l];
                quo_next[l] = {in_quo[l][Q_W-2:0], 1'b0};
            end
        end
    end

    assign valid_next = en ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            den_reg  <= in_den;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_den   = den_reg;
    assign out_quo   = quo_reg;
    assign out_side  = side_reg;

endmodule

[design/fwsk_cordic_cell.sv]
// one vectoring cordic iteration for all four wheels
`timescale 1ns / 1ps

module fwsk_cordic_cell #(
    parameter int STAGE  = 0,
    parameter int SIDE_W = 1
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  fwsk_pkg::vec_t [3:0]      in_vec,
    input  logic [SIDE_W-1:0]         in_side,
    output logic                      out_valid,
    output fwsk_pkg::vec_t [3:0]      out_vec,
    output logic [SIDE_W-1:0]         out_side
);

    localparam logic signed [fwsk_pkg::ANG_W-1:0] ATAN_STEP =
        $signed(fwsk_pkg::ANG_W'(fwsk_pkg::ATAN_TAB[STAGE]));

    logic                 valid_reg, valid_next;
    fwsk_pkg::vec_t [3:0] vec_reg, vec_next;
    logic [SIDE_W-1:0]    side_reg;
    logic signed [fwsk_pkg::VEC_W-1:0] sx, sy;

    // rotate each vector toward the x axis
    always_comb begin
        sx = '0;
        sy = '0;
        for (int w = 0; w < 4; w++) begin
            sx = fwsk_pkg::shr_tz(in_vec[w].px, STAGE);
            sy = fwsk_pkg::shr_tz(in_vec[w].py, STAGE);
            if (in_vec[w].py < 0) begin
                vec_next[w].px = in_vec[w].px - sy;
                vec_next[w].py = in_vec[w].py + sx;
                vec_next[w].z  = in_vec[w].z - ATAN_STEP;
            end else begin
                vec_next[w].px = in_vec[w].px + sy;
                vec_next[w].py = in_vec[w].py - sx;
                vec_next[w].z  = in_vec[w].z + ATAN_STEP;
            end
        end
    end

    assign valid_next = en ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vec_reg  <= vec_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;
    assign out_side  = side_reg;

endmodule

[design/four_wheel_steer_kinematics.sv]
// pipeline: radius divider cells, cordic cells, stages a to d, power divider cells
// and output register; throughput: one word per cycle unless the result word stalls
// a stalled result word holds the whole chain, so s_tready follows m_tready while it waits
// reset: synchronous active-low aresetn clears all valid bits and loads
// the register defaults; payload registers are not reset
`timescale 1ns / 1ps
`include "assert_macros.svh"

module four_wheel_steer_kinematics #(
    parameter int CORDIC_STAGES = fwsk_pkg::CORDIC_STAGES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration write port
    input  logic         cfg_wr_en,
    input  logic [7:0]   cfg_index,
    input  logic [14:0]  cfg_wdata,
    // input words
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // throttle[15:0], steer[31:16]
    // result words
    output logic         m_tvalid,
    input  logic         m_tready,
    // angle_front_left[14:0], angle_front_right[29:15], angle_rear_left[44:30],
    // angle_rear_right[59:45], power_front_left[75:60], power_front_right[91:76],
    // power_rear_left[107:92], power_rear_right[123:108], zero[127:124]
    output logic [127:0] m_tdata
);

    localparam int RQ_W   = fwsk_pkg::RQ_W;
    localparam int RDEN_W = fwsk_pkg::RDEN_W;
    localparam int LEN_W  = fwsk_pkg::LEN_W;
    localparam int VEC_W  = fwsk_pkg::VEC_W;
    localparam int PREM_W = fwsk_pkg::PREM_W;
    localparam int PQ_W   = fwsk_pkg::PQ_W;
    localparam int RSIDE_W = 18;
    localparam int CSIDE_W = 25;
    localparam int PSIDE_W = 78;

    // configuration registers
    logic [14:0] min_radius_reg, half_wheelbase_reg, half_track_reg;
    logic [11:0] steer_deadband_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_radius_reg     <= fwsk_pkg::MIN_RADIUS_RST;
            half_wheelbase_reg <= fwsk_pkg::HALF_WHEELBASE_RST;
            half_track_reg     <= fwsk_pkg::HALF_TRACK_RST;
            steer_deadband_reg <= fwsk_pkg::STEER_DEADBAND_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                fwsk_pkg::REG_MIN_RADIUS:     min_radius_reg     <= cfg_wdata;
                fwsk_pkg::REG_HALF_WHEELBASE: half_wheelbase_reg <= cfg_wdata;
                fwsk_pkg::REG_HALF_TRACK:     half_track_reg     <= cfg_wdata;
                fwsk_pkg::REG_STEER_DEADBAND: steer_deadband_reg <= cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    // global advance: the chain moves unless the result word is stuck
    logic en;
    logic out_valid_reg, out_valid_next;
    assign en = !out_valid_reg || m_tready;
    assign s_tready = en;

    // input decode: steer magnitude and straight-drive test
    logic signed [16:0] st_ext;
    logic [RDEN_W-1:0]  st_mag;
    logic               bypass_in;
    assign st_ext    = {s_tdata[31], s_tdata[31:16]};
    assign st_mag    = st_ext[16] ? RDEN_W'(-st_ext) : RDEN_W'(st_ext);
    assign bypass_in = st_mag <= RDEN_W'(steer_deadband_reg);

    // radius divider chain, one quotient bit per cell
    logic                     rd_valid [RQ_W+1];
    logic [0:0][RQ_W-1:0]     rd_rem   [RQ_W+1];
    logic [RDEN_W-1:0]        rd_den   [RQ_W+1];
    logic [0:0][RQ_W-1:0]     rd_quo   [RQ_W+1];
    logic [RSIDE_W-1:0]       rd_side  [RQ_W+1];

    assign rd_valid[0] = s_tvalid;
    assign rd_rem[0]   = {min_radius_reg, 12'd0};
    assign rd_den[0]   = st_mag;
    assign rd_quo[0]   = '0;
    assign rd_side[0]  = {s_tdata[31], bypass_in, s_tdata[15:0]};

    for (genvar k = 0; k < RQ_W; k++) begin : g_rdiv
        fwsk_div_cell #(
            .LANES (1), .REM_W(RQ_W), .DEN_W(RDEN_W), .Q_W(RQ_W),
            .SHIFT (RQ_W - 1 - k), .SIDE_W(RSIDE_W)
        ) u_cell (
            .aclk     (aclk),           .aresetn (aresetn),       .en       (en),
            .in_valid (rd_valid[k]),    .in_rem  (rd_rem[k]),     .in_den   (rd_den[k]),
            .in_quo   (rd_quo[k]),      .in_side (rd_side[k]),
            .out_valid(rd_valid[k+1]),  .out_rem (rd_rem[k+1]),   .out_den  (rd_den[k+1]),
            .out_quo  (rd_quo[k+1]),    .out_side(rd_side[k+1])
        );
    end

    // signed radius and per-wheel start vectors
    logic signed [RQ_W:0]   radius;
    logic signed [RQ_W+1:0] r_ext;
    logic signed [RQ_W+1:0] dy [4];
    logic [RQ_W+1:0]        dy_mag;
    logic signed [VEC_W-1:0] py_front;
    fwsk_pkg::vec_t [3:0]   cv_init;
    logic [7:0]             dy_flags;

    assign radius   = rd_side[RQ_W][17] ? -$signed({1'b0, rd_quo[RQ_W][0]})
                                        :  $signed({1'b0, rd_quo[RQ_W][0]});
    assign r_ext    = {radius[RQ_W], radius};
    assign py_front = $signed(VEC_W'(half_wheelbase_reg) << 16);

    always_comb begin
        dy[0] = r_ext - $signed((RQ_W+2)'(half_track_reg));
        dy[1] = r_ext + $signed((RQ_W+2)'(half_track_reg));
        dy[2] = dy[0];
        dy[3] = dy[1];
        dy_mag = '0;
        for (int w = 0; w < 4; w++) begin
            dy_mag = dy[w][RQ_W+1] ? (RQ_W+2)'(-dy[w]) : (RQ_W+2)'(dy[w]);
            cv_init[w].px = $signed(VEC_W'(dy_mag) << 16);
            cv_init[w].py = (w < 2) ? py_front : -py_front;
            cv_init[w].z  = '0;
            dy_flags[2*w]   = dy[w][RQ_W+1];
            dy_flags[2*w+1] = (dy[w] == '0);
        end
    end

    // cordic chain, one iteration per cell
    logic                 cv_valid [CORDIC_STAGES+1];
    fwsk_pkg::vec_t [3:0] cv_vec   [CORDIC_STAGES+1];
    logic [CSIDE_W-1:0]   cv_side  [CORDIC_STAGES+1];

    assign cv_valid[0] = rd_valid[RQ_W];
    assign cv_vec[0]   = cv_init;
    assign cv_side[0]  = {dy_flags, rd_side[RQ_W][16:0]};

    for (genvar c = 0; c < CORDIC_STAGES; c++) begin : g_cordic
        fwsk_cordic_cell #(.STAGE(c), .SIDE_W(CSIDE_W)) u_cell (
            .aclk     (aclk),          .aresetn (aresetn),     .en      (en),
            .in_valid (cv_valid[c]),   .in_vec  (cv_vec[c]),   .in_side (cv_side[c]),
            .out_valid(cv_valid[c+1]), .out_vec (cv_vec[c+1]), .out_side(cv_side[c+1])
        );
    end

    // stage a: angle scaling product and wheel lengths
    logic               a_valid_reg;
    logic [15:0]        a_m_reg   [4];
    logic [15:0]        a_m_next  [4];
    logic               a_zneg_reg [4];
    logic [LEN_W-1:0]   a_len_reg [4];
    logic [LEN_W-1:0]   a_len_next [4];
    logic [CSIDE_W-1:0] a_side_reg;
    logic [31:0]        zmag;
    logic [45:0]        zprod;

    always_comb begin
        zmag = '0;
        zprod = '0;
        for (int w = 0; w < 4; w++) begin
            zmag = cv_vec[CORDIC_STAGES][w].z[32] ? 32'(-cv_vec[CORDIC_STAGES][w].z)
                                                  : 32'(cv_vec[CORDIC_STAGES][w].z);
            zprod = 46'(zmag) * 46'd9000 + 46'(1 << 29);
            a_m_next[w] = zprod[45:30];
            a_len_next[w] = cv_vec[CORDIC_STAGES][w].px[VEC_W-1] ? '0
                          : cv_vec[CORDIC_STAGES][w].px[LEN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int w = 0; w < 4; w++) begin
                a_m_reg[w]    <= a_m_next[w];
                a_zneg_reg[w] <= cv_vec[CORDIC_STAGES][w].z[32];
                a_len_reg[w]  <= a_len_next[w];
            end
            a_side_reg <= cv_side[CORDIC_STAGES];
        end
    end

    // stage b: final angles and pairwise length maxima
    logic                    b_valid_reg;
    logic signed [14:0]      b_ang_reg  [4];
    logic signed [14:0]      b_ang_next [4];
    logic [LEN_W-1:0]        b_len_reg  [4];
    logic [LEN_W-1:0]        b_max01_reg, b_max23_reg;
    logic [15:0]             b_thr_reg;
    logic                    b_bypass_reg;
    logic [13:0]             m_sat;
    logic signed [14:0]      h;

    always_comb begin
        m_sat = '0;
        h = '0;
        for (int w = 0; w < 4; w++) begin
            m_sat = (a_m_reg[w] > 16'(fwsk_pkg::ANGLE_MAX)) ? fwsk_pkg::ANGLE_MAX
                                                             : a_m_reg[w][13:0];
            h = a_zneg_reg[w] ? -$signed({1'b0, m_sat}) : $signed({1'b0, m_sat});
            if (a_side_reg[17+2*w]) begin
                h = -h;
            end
            // wheel on the turn axis points straight across, or straight ahead if half wheelbase is zero
            if (a_side_reg[18+2*w]) begin
                if (half_wheelbase_reg == '0) begin
                    h = '0;
                end else if (w < 2) begin
                    h = $signed({1'b0, fwsk_pkg::ANGLE_MAX});
                end else begin
                    h = -$signed({1'b0, fwsk_pkg::ANGLE_MAX});
                end
            end
            b_ang_next[w] = h;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int w = 0; w < 4; w++) begin
                b_ang_reg[w] <= b_ang_next[w];
                b_len_reg[w] <= a_len_reg[w];
            end
            b_max01_reg  <= (a_len_reg[0] > a_len_reg[1]) ? a_len_reg[0] : a_len_reg[1];
            b_max23_reg  <= (a_len_reg[2] > a_len_reg[3]) ? a_len_reg[2] : a_len_reg[3];
            b_thr_reg    <= a_side_reg[15:0];
            b_bypass_reg <= a_side_reg[16];
        end
    end

    // stage c: longest wheel and partial products of throttle times length
    logic               c_valid_reg;
    logic [LEN_W-1:0]   c_rmax_reg;
    logic [39:0]        c_pplo_reg [4];
    logic [38:0]        c_pphi_reg [4];
    logic [59:0]        c_ang_reg;
    logic [15:0]        c_thr_reg;
    logic               c_bypass_reg;
    logic [15:0]        thr_mag;

    assign thr_mag = b_thr_reg[15] ? 16'(-$signed(b_thr_reg)) : b_thr_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int w = 0; w < 4; w++) begin
                c_pplo_reg[w] <= 40'(thr_mag) * 40'(b_len_reg[w][23:0]);
                c_pphi_reg[w] <= 39'(thr_mag) * 39'(b_len_reg[w][LEN_W-1:24]);
                c_ang_reg[15*w +: 15] <= b_ang_reg[w];
            end
            c_rmax_reg   <= (b_max01_reg > b_max23_reg) ? b_max01_reg : b_max23_reg;
            c_thr_reg    <= b_thr_reg;
            c_bypass_reg <= b_bypass_reg;
        end
    end

    // stage d: assemble the power dividends
    logic                     d_valid_reg;
    logic [3:0][PREM_W-1:0]   d_div_reg;
    logic [LEN_W-1:0]         d_rmax_reg;
    logic [PSIDE_W-1:0]       d_side_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int w = 0; w < 4; w++) begin
                d_div_reg[w] <= (PREM_W'(c_pphi_reg[w]) << 24) + PREM_W'(c_pplo_reg[w]);
            end
            d_rmax_reg <= c_rmax_reg;
            d_side_reg <= {(c_rmax_reg == '0), c_bypass_reg, c_thr_reg, c_ang_reg};
        end
    end

    // valid bits of the scalar stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= cv_valid[CORDIC_STAGES];
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    // power divider chain, four lanes over the common longest length
    logic                     pv_valid [PQ_W+1];
    logic [3:0][PREM_W-1:0]   pv_rem   [PQ_W+1];
    logic [LEN_W-1:0]         pv_den   [PQ_W+1];
    logic [3:0][PQ_W-1:0]     pv_quo   [PQ_W+1];
    logic [PSIDE_W-1:0]       pv_side  [PQ_W+1];

    assign pv_valid[0] = d_valid_reg;
    assign pv_rem[0]   = d_div_reg;
    assign pv_den[0]   = d_rmax_reg;
    assign pv_quo[0]   = '0;
    assign pv_side[0]  = d_side_reg;

    for (genvar k = 0; k < PQ_W; k++) begin : g_pdiv
        fwsk_div_cell #(
            .LANES (4), .REM_W(PREM_W), .DEN_W(LEN_W), .Q_W(PQ_W),
            .SHIFT (PQ_W - 1 - k), .SIDE_W(PSIDE_W)
        ) u_cell (
            .aclk     (aclk),           .aresetn (aresetn),       .en       (en),
            .in_valid (pv_valid[k]),    .in_rem  (pv_rem[k]),     .in_den   (pv_den[k]),
            .in_quo   (pv_quo[k]),      .in_side (pv_side[k]),
            .out_valid(pv_valid[k+1]),  .out_rem (pv_rem[k+1]),   .out_den  (pv_den[k+1]),
            .out_quo  (pv_quo[k+1]),    .out_side(pv_side[k+1])
        );
    end

    // output word: signs, saturation, straight-drive override and zero-length override
    logic [127:0]       out_data_reg, out_data_next;
    logic [15:0]        thr_f;
    logic signed [16:0] p;

    always_comb begin
        thr_f = pv_side[PQ_W][75:60];
        out_data_next = '0;
        p = '0;
        for (int w = 0; w < 4; w++) begin
            p = thr_f[15] ? -$signed({1'b0, pv_quo[PQ_W][w]})
                          :  $signed({1'b0, pv_quo[PQ_W][w]});
            if (p > 17'sd32767) begin
                p = 17'sd32767;
            end else if (p < -17'sd32768) begin
                p = -17'sd32768;
            end
            if (pv_side[PQ_W][76]) begin
                out_data_next[15*w +: 15]      = '0;
                out_data_next[60+16*w +: 16]   = thr_f;
            end else begin
                out_data_next[15*w +: 15]      = pv_side[PQ_W][15*w +: 15];
                out_data_next[60+16*w +: 16]   = pv_side[PQ_W][77] ? thr_f : p[15:0];
            end
        end
    end

    assign out_valid_next = en ? pv_valid[PQ_W] : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // checks
    `FWSK_ASSERT_IMPL(a_stall_only_on_backpressure, aclk, aresetn, !s_tready, m_tvalid && !m_tready, "input stalled without a blocked result word")
    `FWSK_ASSERT_NEXT(a_divider_drains, aclk, aresetn, pv_valid[PQ_W] && en, m_tvalid, "finished word did not reach the output")
    `FWSK_ASSERT_IMPL(a_angle_range, aclk, aresetn, m_tvalid, ($signed(m_tdata[14:0]) <= 15'sd9000) && ($signed(m_tdata[14:0]) >= -15'sd9000), "front left angle out of range")

endmodule

[tb/tb_top.sv]
// testbench for the four wheel steering kinematics block: directed table, then random words
`timescale 1ns / 1ps

module tb_top;

    localparam int STAGES    = fwsk_pkg::CORDIC_STAGES_DEF;
    localparam int LATENCY   = 48 + STAGES;
    localparam int CYC_LIMIT = 400000;
    localparam int HOLD_LEN  = 400;
    localparam int RAND_PER  = 140;

    logic         aclk;
    logic         aresetn;
    logic         cfg_wr_en;
    logic [7:0]   cfg_index;
    logic [14:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [31:0]  s_tdata;   // throttle[15:0], steer[31:16]
    logic         m_tvalid;
    logic         m_tready;
    // angles fl, fr, rl, rr at 15 bits each, then powers fl, fr, rl, rr at 16 bits each
    logic [127:0] m_tdata;

    four_wheel_steer_kinematics #(.CORDIC_STAGES(STAGES)) u_top (.*);

    // shadow copy of the registers
    logic [14:0] min_radius_q, half_wheelbase_q, half_track_q;
    logic [11:0] deadband_q;

    logic [127:0] pending_results[$];
    int  errors;
    int  mismatches;
    int  cycles;
    int  idle_mode;    // 0: sender 16%, receiver 64%; 1: swapped; 2: none
    bit  hold_go;
    int  hold_left;

    // directed rows: expected value typed in where check_typed is set
    typedef struct {
        logic [15:0]  thr;
        logic [15:0]  st;
        bit           check_typed;
        logic [127:0] typed;
    } row_t;

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint unsigned magn(longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    function automatic longint shift_tz(longint v, int s);
        longint unsigned m;
        m = magn(v) >> s;
        return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    // one wheel: steering angle and cordic length
    task automatic wheel_angle(input longint r, input longint wx, input longint wy,
                               output longint ang, output longint unsigned len);
        longint dy, px, py, z, sx, sy, h;
        longint unsigned m;
        dy = r - wy;
        px = longint'(magn(dy) << 16);
        py = wx * 65536;
        z = 0;
        for (int i = 0; i < STAGES; i++) begin
            sx = shift_tz(px, i);
            sy = shift_tz(py, i);
            if (py < 0) begin
                px = px - sy;
                py = py + sx;
                z = z - longint'(fwsk_pkg::ATAN_TAB[i]);
            end else begin
                px = px + sy;
                py = py - sx;
                z = z + longint'(fwsk_pkg::ATAN_TAB[i]);
            end
        end
        m = (magn(z) * 9000 + (64'd1 << 29)) >> 30;
        if (m > 9000) m = 9000;
        h = z < 0 ? -longint'(m) : longint'(m);
        if (dy < 0) h = -h;
        if (dy == 0) h = wx > 0 ? 9000 : (wx < 0 ? -9000 : 0);
        ang = h;
        len = px < 0 ? 0 : px;
    endtask

    // packs the eight fields into a result word
    function automatic logic [127:0] pack_result(longint ang[4], longint pwr[4]);
        logic [127:0] w;
        w = '0;
        for (int k = 0; k < 4; k++) begin
            w[15*k +: 15] = ang[k][14:0];
            w[60 + 16*k +: 16] = pwr[k][15:0];
        end
        return w;
    endfunction

    // steering angles and wheel powers for one command
    task automatic steer_kinematics(input logic [15:0] thr_in, input logic [15:0] st_in,
                                    output logic [127:0] res);
        longint thr, st, r, hw, ht, p;
        longint unsigned q, rmax, m;
        longint ang[4], pwr[4];
        longint unsigned len[4];
        thr = longint'($signed(thr_in));
        st = longint'($signed(st_in));
        if (magn(st) <= deadband_q) begin
            for (int k = 0; k < 4; k++) begin
                ang[k] = 0;
                pwr[k] = thr;
            end
        end else begin
            q = (longint'(min_radius_q) << 12) / magn(st);
            r = st < 0 ? -longint'(q) : longint'(q);
            hw = half_wheelbase_q;
            ht = half_track_q;
            wheel_angle(r, hw, ht, ang[0], len[0]);
            wheel_angle(r, hw, -ht, ang[1], len[1]);
            wheel_angle(r, -hw, ht, ang[2], len[2]);
            wheel_angle(r, -hw, -ht, ang[3], len[3]);
            rmax = 0;
            for (int k = 0; k < 4; k++) if (len[k] > rmax) rmax = len[k];
            for (int k = 0; k < 4; k++) begin
                if (rmax == 0) begin
                    p = thr;
                end else begin
                    m = magn(thr) * len[k] / rmax;
                    p = thr < 0 ? -longint'(m) : longint'(m);
                    if (p > 32767) p = 32767;
                    if (p < -32768) p = -32768;
                end
                pwr[k] = p;
            end
        end
        res = pack_result(ang, pwr);
    endtask

    // straight drive: all angles zero, all powers equal throttle
    function automatic logic [127:0] straight(logic [15:0] thr);
        longint ang[4], pwr[4];
        for (int k = 0; k < 4; k++) begin
            ang[k] = 0;
            pwr[k] = longint'($signed(thr));
        end
        return pack_result(ang, pwr);
    endfunction

    // register write, one per cycle; caller lowers the enable
    task automatic write_reg(input logic [7:0] idx, input logic [14:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            fwsk_pkg::REG_MIN_RADIUS:     min_radius_q = val;
            fwsk_pkg::REG_HALF_WHEELBASE: half_wheelbase_q = val;
            fwsk_pkg::REG_HALF_TRACK:     half_track_q = val;
            fwsk_pkg::REG_STEER_DEADBAND: deadband_q = val[11:0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(input logic [14:0] mr, input logic [14:0] hw,
                                input logic [14:0] ht, input logic [14:0] db);
        write_reg(fwsk_pkg::REG_MIN_RADIUS, mr);
        write_reg(fwsk_pkg::REG_HALF_WHEELBASE, hw);
        write_reg(fwsk_pkg::REG_HALF_TRACK, ht);
        write_reg(fwsk_pkg::REG_STEER_DEADBAND, db);
        cfg_wr_en <= 1'b0;
    endtask

    // offer one word, with a random gap first when the sender idles
    task automatic send_word(input logic [15:0] thr, input logic [15:0] st,
                             input bit check_typed, input logic [127:0] typed);
        logic [127:0] res;
        if (idle_mode == 0 && $urandom_range(99) < 16 ||
            idle_mode == 1 && $urandom_range(99) < 64) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {st, thr};
        do @(posedge aclk); while (!s_tready);
        steer_kinematics(thr, st, res);
        pending_results.push_back(check_typed ? typed : res);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (LATENCY + 8) @(posedge aclk);
    endtask

    // random steer: half full scale, the rest near the deadband, in the turning range or at 4096
    function automatic logic [15:0] rand_steer();
        int sel;
        int mag;
        sel = $urandom_range(9);
        if (sel < 2) mag = int'(deadband_q) + $urandom_range(2) - 1;
        else if (sel < 4) mag = $urandom_range(4096);
        else if (sel < 5) mag = 4096;
        else return 16'($urandom);
        if (mag < 0) mag = 0;
        return $urandom_range(1) ? 16'(-mag) : 16'(mag);
    endfunction

    // result checker
    always @(posedge aclk) begin
        logic [127:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                errors++;
                if (mismatches++ < 10) $display("unexpected result word %h", m_tdata);
            end else begin
                want = pending_results.pop_front();
                for (int k = 0; k < 8; k++) begin
                    logic [15:0] e, a;
                    e = k < 4 ? 16'(want[15*k +: 15]) : want[60 + 16*(k-4) +: 16];
                    a = k < 4 ? 16'(m_tdata[15*k +: 15]) : m_tdata[60 + 16*(k-4) +: 16];
                    if (e !== a) begin
                        errors++;
                        if (mismatches++ < 10)
                            $display("field %0d mismatch: expected %h actual %h", k, e, a);
                    end
                end
                if (m_tdata[127:124] !== 4'h0) begin
                    errors++;
                    if (mismatches++ < 10) $display("pad bits not zero: %h", m_tdata[127:124]);
                end
            end
        end
    end

    // receiver readiness, with one long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_left <= 0;
        end else if (hold_go) begin
            hold_left <= HOLD_LEN;
            m_tready <= 1'b0;
        end else if (hold_left > 1) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            hold_left <= 0;
            if (idle_mode == 0) m_tready <= $urandom_range(99) >= 64;
            else if (idle_mode == 1) m_tready <= $urandom_range(99) >= 16;
            else m_tready <= 1'b1;
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        row_t rows[$];
        cycles = 0;
        errors = 0;
        mismatches = 0;
        idle_mode = 0;
        hold_go = 1'b0;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        min_radius_q = fwsk_pkg::MIN_RADIUS_RST;
        half_wheelbase_q = fwsk_pkg::HALF_WHEELBASE_RST;
        half_track_q = fwsk_pkg::HALF_TRACK_RST;
        deadband_q = fwsk_pkg::STEER_DEADBAND_RST;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // straight drive and deadband edges on reset defaults, then turns
        rows.push_back('{16'h7fff, 16'h0000, 1, straight(16'h7fff)});
        rows.push_back('{16'h8000, 16'h0000, 1, straight(16'h8000)});
        rows.push_back('{16'd100, 16'd20, 1, straight(16'd100)});
        rows.push_back('{16'hfffb, -16'sd20, 1, straight(16'hfffb)});
        rows.push_back('{16'd4096, 16'd21, 0, '0});
        rows.push_back('{16'd4096, -16'sd21, 0, '0});
        rows.push_back('{16'h7fff, 16'h7fff, 0, '0});
        rows.push_back('{16'h8000, 16'h8000, 0, '0});
        rows.push_back('{16'd4096, 16'd4096, 0, '0});
        rows.push_back('{-16'sd4096, -16'sd4096, 0, '0});
        rows.push_back('{16'h0000, 16'd5000, 0, '0});
        rows.push_back('{16'h7fff, 16'h8000, 0, '0});
        rows.push_back('{16'h8000, 16'h7fff, 0, '0});
        rows.push_back('{16'hffff, 16'h0001, 1, straight(16'hffff)});
        foreach (rows[i]) send_word(rows[i].thr, rows[i].st, rows[i].check_typed, rows[i].typed);
        drain();

        // wheel on the turn axis: radius equals half track at steer of one
        set_geometry(15'd4096, 15'd2048, 15'd4096, 15'd20);
        send_word(16'd3000, 16'd4096, 0, '0);
        send_word(16'd3000, -16'sd4096, 0, '0);
        drain();

        // an index beyond the register file changes nothing
        write_reg(8'd200, 15'h7fff);
        cfg_wr_en <= 1'b0;

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_geometry(15'd1, 15'd0, 15'd0, 15'd0);
                1: set_geometry(15'h7fff, 15'h7fff, 15'h7fff, 15'h7fff);
                2: set_geometry(15'd4096, 15'd2048, 15'd4096, 15'd20);
                3: set_geometry(15'd8192, 15'd1, 15'h7fff, 15'd4095);
                default: set_geometry(15'($urandom_range(1, 32767)), 15'($urandom),
                                      15'($urandom), 15'($urandom_range(4095)));
            endcase
            idle_mode = ph < 2 ? 0 : (ph < 4 ? 1 : 2);
            // long receiver hold while the sender keeps offering
            if (ph == 4) begin
                hold_go = 1'b1;
                repeat (2) @(posedge aclk);
                hold_go = 1'b0;
            end
            for (int n = 0; n < RAND_PER; n++)
                send_word(16'($urandom), rand_steer(), 0, '0);
            drain();
        end

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
